FILE: src/heap_sort_batch_macros.svh
// assertion macros for the batch sorter
`ifndef HEAP_SORT_BATCH_MACROS_SVH
`define HEAP_SORT_BATCH_MACROS_SVH
`ifndef SYNTHESIS
`define HSB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap_sort_batch: same-cycle check failed");
`define HSB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap_sort_batch: next-cycle check failed");
`else
`define HSB_ASSERT_IMP(label, ante, cons)
`define HSB_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: src/hsb_pkg.sv
// shared types for the batch sorter
package hsb_pkg;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } hsb_state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic shl;
  } cell_ctrl_t;

endpackage

FILE: src/heap_sort_batch.sv
// batch sorter top level: chain of sorting cells and fill/drain control
//
//   channel | ports                                       | handshake
//   --------+---------------------------------------------+-----------------
//   input   | in_value, in_last_in                        | in_valid/in_stall
//   result  | out_sorted_value, out_last_out, out_overflow | out_valid/out_stall
//
// each accepted input beat is inserted into the sorted chain (one compare per cell);
// a beat that arrives with the chain full is dropped and sets out_overflow.
// after the closing beat the chain drains one result per cycle from its low end.
// input is stalled while a batch drains; output stalls freeze the chain.
// reset clears the cell valid bits, the fill count and the overflow flag.
module heap_sort_batch
  import hsb_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  input  logic               in_last_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_sorted_value,
  output logic               out_last_out,
  output logic               out_overflow
);

`include "heap_sort_batch_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);

  hsb_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               flag_r, flag_nxt;
  cell_ctrl_t         ctrl;
  logic               in_acc, out_acc, full;

  logic signed [31:0] cell_val [DEPTH];
  logic [DEPTH-1:0]   cell_valid;
  logic [DEPTH-1:0]   cell_gt;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] l_val, r_val;
    logic               l_valid, l_gt, r_valid;
    if (i == 0) begin : g_first
      assign l_val   = '0;
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
    end else begin : g_mid
      assign l_val   = cell_val[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign r_val   = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_val   = cell_val[i+1];
      assign r_valid = cell_valid[i+1];
    end
    hsb_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .in_value    (in_value),
      .left_val    (l_val),
      .left_valid  (l_valid),
      .left_gt     (l_gt),
      .right_val   (r_val),
      .right_valid (r_valid),
      .val         (cell_val[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  assign full             = (cnt_r == CNT_W'(DEPTH));
  assign in_stall         = (state_r == ST_DRAIN);
  assign in_acc           = in_valid && !in_stall;
  assign out_valid        = (state_r == ST_DRAIN) && cell_valid[0];
  assign out_acc          = out_valid && !out_stall;
  assign out_sorted_value = cell_val[0];
  assign out_last_out     = !cell_valid[1];
  assign out_overflow     = flag_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    flag_nxt  = flag_r;
    ctrl.ins  = 1'b0;
    ctrl.shl  = 1'b0;
    unique case (state_r)
      ST_FILL: begin
        if (in_acc) begin
          if (full) begin
            flag_nxt = 1'b1;
          end else begin
            ctrl.ins = 1'b1;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
          if (in_last_in) begin
            state_nxt = ST_DRAIN;
            cnt_nxt   = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          ctrl.shl = 1'b1;
          if (out_last_out) begin
            state_nxt = ST_FILL;
            flag_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      cnt_r   <= '0;
      flag_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      flag_r  <= flag_nxt;
    end
  end

  // a draining chain always has its low cell occupied
  `HSB_ASSERT_IMP(a_drain_nonempty, state_r == ST_DRAIN, cell_valid[0])
  // results leave in ascending order
  `HSB_ASSERT_IMP(a_sorted_head, out_valid && cell_valid[1], cell_val[0] <= cell_val[1])
  // the final beat empties the chain and reopens the input
  `HSB_ASSERT_NXT(a_batch_done, out_acc && out_last_out,
                  state_r == ST_FILL && !cell_valid[0] && cnt_r == '0 && !flag_r)

endmodule

FILE: src/hsb_cell.sv
// one cell of the sorted chain: holds one value and its valid bit
module hsb_cell
  import hsb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctrl_t         ctrl,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] left_val,
  input  logic               left_valid,
  input  logic               left_gt,
  input  logic signed [31:0] right_val,
  input  logic               right_valid,
  output logic signed [31:0] val,
  output logic               valid,
  output logic               gt
);

  logic signed [31:0] val_r, val_nxt;
  logic               valid_r, valid_nxt;

  // empty cells count as larger than anything
  assign gt = !valid_r || (val_r > in_value);

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctrl.ins && gt) begin
      val_nxt   = left_gt ? left_val : in_value;
      valid_nxt = left_valid;
    end else if (ctrl.shl) begin
      val_nxt   = right_val;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign valid = valid_r;

endmodule
